>>> src/jaj_pkg.sv
package jaj_pkg;

  // Item geometry
  localparam int AXIS_W     = 16;
  localparam int NUM_AXES   = 6;
  localparam int NUM_LANES  = 6;
  localparam int BTN_W      = 6;
  localparam int THR_W      = 16;
  localparam int CLAW_W     = 8;
  localparam int PORT_W     = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Arithmetic widths
  localparam int SV_W   = AXIS_W + 1;
  localparam int MAG_W  = AXIS_W + 1;
  localparam int Q_FRAC = 16;
  localparam int Q_W    = Q_FRAC + 1;
  localparam int PROD_W = MAG_W + Q_W;
  localparam int RND_W  = PROD_W - Q_FRAC;
  localparam int CMP_W  = (AXIS_W > THR_W) ? AXIS_W : THR_W;
  localparam int REM_W  = CMP_W + 1;
  localparam int CNT_W  = $clog2(Q_W);
  localparam int TGT_W  = CLAW_W + 2;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(Q_W - 1);

  // Stream packing
  localparam int IN_BITS     = NUM_AXES * AXIS_W + BTN_W;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int BTN_LSB     = NUM_AXES * AXIS_W;
  localparam int OUT_REQ_BIT  = NUM_LANES * AXIS_W;
  localparam int OUT_POS_LSB  = OUT_REQ_BIT + 1;
  localparam int OUT_PORT_LSB = OUT_POS_LSB + CLAW_W;
  localparam int OUT_LIM_BIT  = OUT_PORT_LSB + PORT_W;
  localparam int OUT_BITS     = OUT_LIM_BIT + 1;
  localparam int OUT_DATA_W   = ((OUT_BITS + 7) / 8) * 8;

  // Input axis slots, in packing order
  localparam int AX_BASE     = 0;
  localparam int AX_ROLL     = 1;
  localparam int AX_SHOULDER = 2;
  localparam int AX_UPPER    = 3;
  localparam int AX_ELBOW    = 4;
  localparam int AX_THROTTLE = 5;

  // Rate lanes, in result packing order
  localparam int LN_BASE     = 0;
  localparam int LN_SHOULDER = 1;
  localparam int LN_UPPER    = 2;
  localparam int LN_ELBOW    = 3;
  localparam int LN_TILT     = 4;
  localparam int LN_ROLL     = 5;

  // Button bits
  localparam int BTN_TILT_PLUS  = 0;
  localparam int BTN_TILT_MINUS = 1;
  localparam int BTN_OPEN       = 2;
  localparam int BTN_CLOSE      = 3;
  localparam int BTN_FWD        = 4;
  localparam int BTN_BWD        = 5;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_THROTTLE_ENABLE = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_THROTTLE_MIN    = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] CFG_THROTTLE_MAX    = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] CFG_CLAW_MIN        = CFG_ADDR_W'(3);
  localparam logic [CFG_ADDR_W-1:0] CFG_CLAW_MAX        = CFG_ADDR_W'(4);
  localparam logic [CFG_ADDR_W-1:0] CFG_CLAW_PORT       = CFG_ADDR_W'(5);

  // Register reset values
  localparam logic                     THR_EN_RST   = 1'b1;
  localparam logic signed [THR_W-1:0]  THR_MIN_RST  = THR_W'(-(longint'(1) << (THR_W - 1)));
  localparam logic signed [THR_W-1:0]  THR_MAX_RST  = THR_W'((longint'(1) << (THR_W - 1)) - 1);
  localparam logic [CLAW_W-1:0]        CLAW_MIN_RST = CLAW_W'(8);
  localparam logic [CLAW_W-1:0]        CLAW_MAX_RST = CLAW_W'(63);
  localparam logic [PORT_W-1:0]        PORT_RST     = PORT_W'(12);

  // Q1.(AXIS_W-1) constants, rounded to nearest
  localparam longint FULL       = longint'(1) << (AXIS_W - 1);
  localparam longint SH_FWD_MAG = (7800 * FULL + 5000) / 10000;
  localparam longint UA_FWD_MAG = (9200 * FULL + 5000) / 10000;
  localparam longint SH_BWD_MAG = (9000 * FULL + 5000) / 10000;
  localparam longint UA_BWD_MAG = (8000 * FULL + 5000) / 10000;
  localparam longint DZ_SH_MAG  = (1000 * FULL + 5000) / 10000;
  localparam longint DZ_EL_MAG  = (2000 * FULL + 5000) / 10000;

  localparam logic signed [SV_W-1:0] K_SH_FWD   = SV_W'(-SH_FWD_MAG);
  localparam logic signed [SV_W-1:0] K_UA_FWD   = SV_W'(UA_FWD_MAG);
  localparam logic signed [SV_W-1:0] K_SH_BWD   = SV_W'(SH_BWD_MAG);
  localparam logic signed [SV_W-1:0] K_UA_BWD   = SV_W'(-UA_BWD_MAG);
  localparam logic signed [SV_W-1:0] K_FULL_POS = SV_W'(FULL);
  localparam logic signed [SV_W-1:0] K_FULL_NEG = SV_W'(-FULL);
  localparam logic [MAG_W-1:0]       DZ_SHOULDER = MAG_W'(DZ_SH_MAG);
  localparam logic [MAG_W-1:0]       DZ_ELBOW    = MAG_W'(DZ_EL_MAG);

  localparam logic [Q_W-1:0]    Q_ONE     = Q_W'(longint'(1) << Q_FRAC);
  localparam logic [RND_W-1:0]  R_MAX_POS = RND_W'(FULL - 1);
  localparam logic [RND_W-1:0]  R_MAX_NEG = RND_W'(FULL);
  localparam logic [AXIS_W-1:0] SAT_POS   = AXIS_W'(FULL - 1);
  localparam logic [AXIS_W-1:0] SAT_NEG   = AXIS_W'(-FULL);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_t;

  // Round a sign-magnitude product half away from zero, then saturate.
  function automatic logic [AXIS_W-1:0] round_sat(input logic [PROD_W-1:0] p, input logic neg);
    logic [RND_W-1:0] r;
    r = p[PROD_W-1:Q_FRAC] + RND_W'(p[Q_FRAC-1]);
    if (!neg) begin
      return (r > R_MAX_POS) ? SAT_POS : r[AXIS_W-1:0];
    end
    return (r > R_MAX_NEG) ? SAT_NEG : AXIS_W'(~r + RND_W'(1));
  endfunction

endpackage

>>> src/joystick_to_arm_joint_rates.sv
// Maps one joystick sample (six Q1.15 axes and a button mask) to six saturated Q1.15 joint
// rates scaled by the throttle lever, and steps the claw servo position on fresh open or
// close presses. Every input item gives exactly one result item. A clamp step limits the
// throttle, a restoring divider forms the unsigned Q1.16 throttle factor one quotient bit
// per cycle, six shift-add lanes multiply the rates by that factor one factor bit per
// cycle, and a final step rounds, saturates and loads the output register once it is free;
// the next item can be taken in the cycle after, and none before then. A finished result
// waits in the output register while the next item is accepted. Write configuration only while idle.
module joystick_to_arm_joint_rates (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // base_stick, wrist_roll_axis, shoulder_axis, upper_arm_axis, elbow_axis, throttle_axis,
  // buttons, zero pad
  input  logic [jaj_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // base_rate, shoulder_rate, upper_arm_rate, elbow_rate, wrist_tilt_rate, wrist_roll_rate,
  // claw_request, claw_position, claw_port, claw_at_limit, zero pad
  output logic [jaj_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_we,
  input  logic [jaj_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [jaj_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // Configuration
  logic                                thr_en_r;
  logic signed [jaj_pkg::THR_W-1:0]    thr_min_r;
  logic signed [jaj_pkg::THR_W-1:0]    thr_max_r;
  logic [jaj_pkg::CLAW_W-1:0]          claw_min_r;
  logic [jaj_pkg::CLAW_W-1:0]          claw_max_r;
  logic [jaj_pkg::PORT_W-1:0]          claw_port_r;

  // Control
  jaj_pkg::state_t                     state_r, state_nxt;
  logic [jaj_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [jaj_pkg::CLAW_W-1:0]          claw_pos_r, claw_pos_nxt;
  logic                                latch_r, latch_nxt;
  logic                                out_valid_r, out_valid_nxt;

  // Item and datapath
  logic signed [jaj_pkg::AXIS_W-1:0]   axis_r [jaj_pkg::NUM_AXES];
  logic signed [jaj_pkg::AXIS_W-1:0]   axis_nxt [jaj_pkg::NUM_AXES];
  logic [jaj_pkg::BTN_W-1:0]           btn_r, btn_nxt;
  logic [jaj_pkg::REM_W-1:0]           rem_r, rem_nxt;
  logic [jaj_pkg::CMP_W-1:0]           den_r, den_nxt;
  logic [jaj_pkg::Q_W-1:0]             quo_r, quo_nxt;
  logic                                bypass_r, bypass_nxt;
  logic [jaj_pkg::PROD_W-1:0]          lane_p_r [jaj_pkg::NUM_LANES];
  logic [jaj_pkg::PROD_W-1:0]          lane_p_nxt [jaj_pkg::NUM_LANES];
  logic [jaj_pkg::MAG_W-1:0]           lane_mag_r [jaj_pkg::NUM_LANES];
  logic [jaj_pkg::MAG_W-1:0]           lane_mag_nxt [jaj_pkg::NUM_LANES];
  logic                                lane_neg_r [jaj_pkg::NUM_LANES];
  logic                                lane_neg_nxt [jaj_pkg::NUM_LANES];
  logic [jaj_pkg::OUT_DATA_W-1:0]      out_data_r, out_data_nxt;

  // Working signals
  logic signed [jaj_pkg::SV_W-1:0]     ax_sv [jaj_pkg::NUM_AXES];
  logic [jaj_pkg::MAG_W-1:0]           ax_abs [jaj_pkg::NUM_AXES];
  logic signed [jaj_pkg::SV_W-1:0]     lane_sv [jaj_pkg::NUM_LANES];
  logic [jaj_pkg::MAG_W:0]             lane_sum [jaj_pkg::NUM_LANES];
  logic signed [jaj_pkg::CMP_W-1:0]    thr_x, min_x, max_x, clamp_x;
  logic signed [jaj_pkg::CMP_W:0]      dif_x, rng_x;
  logic [jaj_pkg::REM_W-1:0]           trial;
  logic                                ge;
  logic [jaj_pkg::Q_W-1:0]             q_sel;
  logic                                fwd, bwd, tplus, tminus, bopen, bclose;
  logic signed [jaj_pkg::CLAW_W:0]     cdiff_x, cdiff_rnd;
  logic signed [jaj_pkg::CLAW_W:0]     step_x;
  logic signed [jaj_pkg::TGT_W-1:0]    pos_x, step_ext, up_tgt, dn_tgt, cmin_x, cmax_x;
  logic                                up_ok, dn_ok;
  logic                                fin_load;
  logic                                claw_req, claw_lim;

  assign in_tready  = (state_r == jaj_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    // defaults: hold
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    claw_pos_nxt  = claw_pos_r;
    latch_nxt     = latch_r;
    btn_nxt       = btn_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    quo_nxt       = quo_r;
    bypass_nxt    = bypass_r;
    out_data_nxt  = out_data_r;
    fin_load      = 1'b0;
    claw_req      = 1'b0;
    claw_lim      = 1'b0;
    for (int i = 0; i < jaj_pkg::NUM_AXES; i++) begin
      axis_nxt[i] = axis_r[i];
      ax_sv[i]    = jaj_pkg::SV_W'(axis_r[i]);
      ax_abs[i]   = ax_sv[i][jaj_pkg::SV_W-1] ? jaj_pkg::MAG_W'(-ax_sv[i])
                                              : jaj_pkg::MAG_W'(ax_sv[i]);
    end
    for (int i = 0; i < jaj_pkg::NUM_LANES; i++) begin
      lane_p_nxt[i]   = lane_p_r[i];
      lane_mag_nxt[i] = lane_mag_r[i];
      lane_neg_nxt[i] = lane_neg_r[i];
      lane_sum[i]     = {1'b0, lane_p_r[i][jaj_pkg::PROD_W-1:jaj_pkg::Q_W]}
                      + (lane_p_r[i][0] ? {1'b0, lane_mag_r[i]} : '0);
    end

    fwd    = btn_r[jaj_pkg::BTN_FWD];
    bwd    = btn_r[jaj_pkg::BTN_BWD];
    tplus  = btn_r[jaj_pkg::BTN_TILT_PLUS];
    tminus = btn_r[jaj_pkg::BTN_TILT_MINUS];
    bopen  = btn_r[jaj_pkg::BTN_OPEN];
    bclose = btn_r[jaj_pkg::BTN_CLOSE];

    // Lane operands; forward wins over backward
    lane_sv[jaj_pkg::LN_BASE] = -ax_sv[jaj_pkg::AX_BASE];
    if (fwd) begin
      lane_sv[jaj_pkg::LN_SHOULDER] = jaj_pkg::K_SH_FWD;
      lane_sv[jaj_pkg::LN_UPPER]    = jaj_pkg::K_UA_FWD;
      lane_sv[jaj_pkg::LN_TILT]     = jaj_pkg::K_FULL_NEG;
    end else if (bwd) begin
      lane_sv[jaj_pkg::LN_SHOULDER] = jaj_pkg::K_SH_BWD;
      lane_sv[jaj_pkg::LN_UPPER]    = jaj_pkg::K_UA_BWD;
      lane_sv[jaj_pkg::LN_TILT]     = jaj_pkg::K_FULL_POS;
    end else begin
      lane_sv[jaj_pkg::LN_SHOULDER] =
        (ax_abs[jaj_pkg::AX_SHOULDER] >= jaj_pkg::DZ_SHOULDER) ? -ax_sv[jaj_pkg::AX_SHOULDER]
                                                               : '0;
      lane_sv[jaj_pkg::LN_UPPER] = ax_sv[jaj_pkg::AX_UPPER];
      if (tplus && !tminus) begin
        lane_sv[jaj_pkg::LN_TILT] = jaj_pkg::K_FULL_POS;
      end else if (tminus && !tplus) begin
        lane_sv[jaj_pkg::LN_TILT] = jaj_pkg::K_FULL_NEG;
      end else begin
        lane_sv[jaj_pkg::LN_TILT] = '0;
      end
    end
    lane_sv[jaj_pkg::LN_ELBOW] =
      (ax_abs[jaj_pkg::AX_ELBOW] >= jaj_pkg::DZ_ELBOW) ? ax_sv[jaj_pkg::AX_ELBOW] : '0;
    lane_sv[jaj_pkg::LN_ROLL] = ax_sv[jaj_pkg::AX_ROLL];

    // Throttle clamp and divider operands
    thr_x   = jaj_pkg::CMP_W'(axis_r[jaj_pkg::AX_THROTTLE]);
    min_x   = jaj_pkg::CMP_W'(thr_min_r);
    max_x   = jaj_pkg::CMP_W'(thr_max_r);
    if (thr_x > max_x) begin
      clamp_x = max_x;
    end else if (thr_x < min_x) begin
      clamp_x = min_x;
    end else begin
      clamp_x = thr_x;
    end
    dif_x = (jaj_pkg::CMP_W + 1)'(clamp_x) - (jaj_pkg::CMP_W + 1)'(min_x);
    rng_x = (jaj_pkg::CMP_W + 1)'(max_x) - (jaj_pkg::CMP_W + 1)'(min_x);

    // One restoring step; the first step compares without doubling
    trial = (cnt_r == '0) ? rem_r : {rem_r[jaj_pkg::REM_W-2:0], 1'b0};
    ge    = (trial >= {1'b0, den_r});
    q_sel = bypass_r ? jaj_pkg::Q_ONE : {quo_r[jaj_pkg::Q_W-2:0], ge};

    // Claw step, truncated toward zero
    cdiff_x   = signed'({1'b0, claw_max_r}) - signed'({1'b0, claw_min_r});
    cdiff_rnd = cdiff_x + signed'({{jaj_pkg::CLAW_W{1'b0}}, cdiff_x[jaj_pkg::CLAW_W]});
    step_x    = cdiff_rnd >>> 1;
    step_ext  = jaj_pkg::TGT_W'(step_x);
    pos_x     = signed'({2'b00, claw_pos_r});
    cmin_x    = signed'({2'b00, claw_min_r});
    cmax_x    = signed'({2'b00, claw_max_r});
    up_tgt    = pos_x + step_ext;
    dn_tgt    = pos_x - step_ext;
    up_ok     = (up_tgt <= cmax_x) && (up_tgt >= 0) && (up_tgt <= 255);
    dn_ok     = (dn_tgt >= cmin_x) && (dn_tgt >= 0) && (dn_tgt <= 255);

    case (state_r)
      jaj_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          for (int i = 0; i < jaj_pkg::NUM_AXES; i++) begin
            axis_nxt[i] = in_tdata[i*jaj_pkg::AXIS_W +: jaj_pkg::AXIS_W];
          end
          btn_nxt   = in_tdata[jaj_pkg::BTN_LSB +: jaj_pkg::BTN_W];
          state_nxt = jaj_pkg::ST_PREP;
        end
      end
      jaj_pkg::ST_PREP: begin
        rem_nxt    = jaj_pkg::REM_W'(dif_x);
        den_nxt    = rng_x[jaj_pkg::CMP_W-1:0];
        bypass_nxt = !thr_en_r || !(max_x > min_x);
        for (int i = 0; i < jaj_pkg::NUM_LANES; i++) begin
          lane_neg_nxt[i] = lane_sv[i][jaj_pkg::SV_W-1];
          lane_mag_nxt[i] = lane_sv[i][jaj_pkg::SV_W-1] ? jaj_pkg::MAG_W'(-lane_sv[i])
                                                        : jaj_pkg::MAG_W'(lane_sv[i]);
        end
        cnt_nxt   = '0;
        state_nxt = jaj_pkg::ST_DIV;
      end
      jaj_pkg::ST_DIV: begin
        rem_nxt = ge ? trial - {1'b0, den_r} : trial;
        quo_nxt = {quo_r[jaj_pkg::Q_W-2:0], ge};
        if (cnt_r == jaj_pkg::CNT_LAST) begin
          // load the factor into the low half of every lane
          for (int i = 0; i < jaj_pkg::NUM_LANES; i++) begin
            lane_p_nxt[i] = {jaj_pkg::MAG_W'(0), q_sel};
          end
          cnt_nxt   = '0;
          state_nxt = jaj_pkg::ST_MUL;
        end else begin
          cnt_nxt = cnt_r + jaj_pkg::CNT_W'(1);
        end
      end
      jaj_pkg::ST_MUL: begin
        for (int i = 0; i < jaj_pkg::NUM_LANES; i++) begin
          lane_p_nxt[i] = {lane_sum[i], lane_p_r[i][jaj_pkg::Q_W-1:1]};
        end
        if (cnt_r == jaj_pkg::CNT_LAST) begin
          state_nxt = jaj_pkg::ST_FIN;
        end else begin
          cnt_nxt = cnt_r + jaj_pkg::CNT_W'(1);
        end
      end
      jaj_pkg::ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          fin_load = 1'b1;
          if (bopen && !latch_r) begin
            latch_nxt = 1'b1;
            if (!up_ok) begin
              claw_lim = 1'b1;
            end else if (step_x != 0) begin
              claw_pos_nxt = up_tgt[jaj_pkg::CLAW_W-1:0];
              claw_req     = 1'b1;
            end
          end else if (bclose && !latch_r) begin
            latch_nxt = 1'b1;
            if (!dn_ok) begin
              claw_lim = 1'b1;
            end else if (step_x != 0) begin
              claw_pos_nxt = dn_tgt[jaj_pkg::CLAW_W-1:0];
              claw_req     = 1'b1;
            end
          end else if (!bopen && !bclose) begin
            latch_nxt = 1'b0;
          end
          out_data_nxt = '0;
          for (int i = 0; i < jaj_pkg::NUM_LANES; i++) begin
            out_data_nxt[i*jaj_pkg::AXIS_W +: jaj_pkg::AXIS_W] =
              jaj_pkg::round_sat(lane_p_r[i], lane_neg_r[i]);
          end
          out_data_nxt[jaj_pkg::OUT_REQ_BIT]                        = claw_req;
          out_data_nxt[jaj_pkg::OUT_POS_LSB +: jaj_pkg::CLAW_W]     = claw_pos_nxt;
          out_data_nxt[jaj_pkg::OUT_PORT_LSB +: jaj_pkg::PORT_W]    = claw_port_r;
          out_data_nxt[jaj_pkg::OUT_LIM_BIT]                        = claw_lim;
          state_nxt = jaj_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = jaj_pkg::ST_IDLE;
      end
    endcase

    if (fin_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jaj_pkg::ST_IDLE;
      cnt_r       <= '0;
      claw_pos_r  <= jaj_pkg::CLAW_MAX_RST;
      latch_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      claw_pos_r  <= claw_pos_nxt;
      latch_r     <= latch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_en_r    <= jaj_pkg::THR_EN_RST;
      thr_min_r   <= jaj_pkg::THR_MIN_RST;
      thr_max_r   <= jaj_pkg::THR_MAX_RST;
      claw_min_r  <= jaj_pkg::CLAW_MIN_RST;
      claw_max_r  <= jaj_pkg::CLAW_MAX_RST;
      claw_port_r <= jaj_pkg::PORT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        jaj_pkg::CFG_THROTTLE_ENABLE: thr_en_r    <= cfg_wdata[0];
        jaj_pkg::CFG_THROTTLE_MIN:    thr_min_r   <= cfg_wdata[jaj_pkg::THR_W-1:0];
        jaj_pkg::CFG_THROTTLE_MAX:    thr_max_r   <= cfg_wdata[jaj_pkg::THR_W-1:0];
        jaj_pkg::CFG_CLAW_MIN:        claw_min_r  <= cfg_wdata[jaj_pkg::CLAW_W-1:0];
        jaj_pkg::CFG_CLAW_MAX:        claw_max_r  <= cfg_wdata[jaj_pkg::CLAW_W-1:0];
        jaj_pkg::CFG_CLAW_PORT:       claw_port_r <= cfg_wdata[jaj_pkg::PORT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < jaj_pkg::NUM_AXES; i++) begin
      axis_r[i] <= axis_nxt[i];
    end
    for (int i = 0; i < jaj_pkg::NUM_LANES; i++) begin
      lane_p_r[i]   <= lane_p_nxt[i];
      lane_mag_r[i] <= lane_mag_nxt[i];
      lane_neg_r[i] <= lane_neg_nxt[i];
    end
    btn_r      <= btn_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    quo_r      <= quo_nxt;
    bypass_r   <= bypass_nxt;
    out_data_r <= out_data_nxt;
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == jaj_pkg::ST_PREP)
    else $error("accepted item did not start the clamp step");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == jaj_pkg::ST_DIV || state_r == jaj_pkg::ST_MUL) |-> cnt_r <= jaj_pkg::CNT_LAST)
    else $error("step counter ran past the last factor bit");

  a_req_lim_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[jaj_pkg::OUT_REQ_BIT] && out_data_r[jaj_pkg::OUT_LIM_BIT]))
    else $error("claw request and limit flagged on the same item");

  a_claw_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fin_load |=> $stable(claw_pos_r))
    else $error("claw position moved without a finished item");

  a_claw_req_moves: assert property (@(posedge clk) disable iff (!rst_n)
    fin_load && claw_req |=> claw_pos_r != $past(claw_pos_r))
    else $error("claw request without a position change");

endmodule

>>> tb/sv/tb.sv
import jaj_pkg::*;

typedef struct packed {
  logic                             lim;
  logic [PORT_W-1:0]                port;
  logic [CLAW_W-1:0]                pos;
  logic                             req;
  logic [NUM_LANES-1:0][AXIS_W-1:0] rates;
} joint_result_t;

class joint_rate_scoreboard;
  localparam longint AXIS_ONE = longint'(1) << (AXIS_W - 1);
  localparam longint UNITY_Q  = longint'(1) << 16;
  localparam longint CLAW_TOP = (longint'(1) << CLAW_W) - 1;

  bit            thr_en;
  longint        thr_lo;
  longint        thr_hi;
  int            claw_lo;
  int            claw_hi;
  int            claw_port;
  int            claw_pos;
  bit            press_held;
  joint_result_t rates_due[$];
  int            mismatches;
  int            results_seen;

  function new();
    thr_en       = 1'b1;
    thr_lo       = -32768;
    thr_hi       = 32767;
    claw_lo      = 8;
    claw_hi      = 63;
    claw_port    = 12;
    claw_pos     = 63;
    press_held   = 1'b0;
    mismatches   = 0;
    results_seen = 0;
  endfunction

  function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_THROTTLE_ENABLE: thr_en = v[0];
      CFG_THROTTLE_MIN:    thr_lo = longint'($signed(v[THR_W-1:0]));
      CFG_THROTTLE_MAX:    thr_hi = longint'($signed(v[THR_W-1:0]));
      CFG_CLAW_MIN:        claw_lo = int'(v[CLAW_W-1:0]);
      CFG_CLAW_MAX:        claw_hi = int'(v[CLAW_W-1:0]);
      CFG_CLAW_PORT:       claw_port = int'(v[PORT_W-1:0]);
      default: ;
    endcase
  endfunction

  // Fraction given in ten-thousandths, rounded to nearest at the axis scale
  function longint fixed_const(longint tenk);
    longint m;
    longint r;
    m = (tenk < 0) ? -tenk : tenk;
    r = (m * AXIS_ONE + 5000) / 10000;
    return (tenk < 0) ? -r : r;
  endfunction

  function longint mag_of(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Multiply by the throttle factor, round half away from zero, saturate
  function logic [AXIS_W-1:0] scaled(longint v, longint q);
    longint p;
    longint r;
    p = v * q;
    r = (mag_of(p) + UNITY_Q / 2) / UNITY_Q;
    if (p < 0) r = -r;
    if (r > AXIS_ONE - 1) r = AXIS_ONE - 1;
    if (r < -AXIS_ONE) r = -AXIS_ONE;
    return AXIS_W'(r);
  endfunction

  function void take_sample(logic [IN_DATA_W-1:0] d);
    longint           ax[NUM_AXES];
    logic [BTN_W-1:0] b;
    longint           q;
    longint           t;
    longint           step;
    longint           tgt;
    joint_result_t    e;
    for (int i = 0; i < NUM_AXES; i++) begin
      ax[i] = longint'($signed(d[i*AXIS_W +: AXIS_W]));
    end
    b = d[BTN_LSB +: BTN_W];
    q = UNITY_Q;
    if (thr_en && thr_hi > thr_lo) begin
      t = ax[AX_THROTTLE];
      if (t > thr_hi) t = thr_hi;
      if (t < thr_lo) t = thr_lo;
      q = ((t - thr_lo) * UNITY_Q) / (thr_hi - thr_lo);
    end
    e = '0;
    e.rates[LN_BASE] = scaled(-ax[AX_BASE], q);
    if (b[BTN_FWD]) begin
      e.rates[LN_SHOULDER] = scaled(fixed_const(-7800), q);
      e.rates[LN_UPPER]    = scaled(fixed_const(9200), q);
      e.rates[LN_TILT]     = scaled(-AXIS_ONE, q);
    end else if (b[BTN_BWD]) begin
      e.rates[LN_SHOULDER] = scaled(fixed_const(9000), q);
      e.rates[LN_UPPER]    = scaled(fixed_const(-8000), q);
      e.rates[LN_TILT]     = scaled(AXIS_ONE, q);
    end else begin
      if (mag_of(ax[AX_SHOULDER]) >= fixed_const(1000)) begin
        e.rates[LN_SHOULDER] = scaled(-ax[AX_SHOULDER], q);
      end
      e.rates[LN_UPPER] = scaled(ax[AX_UPPER], q);
      e.rates[LN_TILT]  = scaled((longint'(b[BTN_TILT_PLUS]) - longint'(b[BTN_TILT_MINUS]))
                                 * AXIS_ONE, q);
    end
    if (mag_of(ax[AX_ELBOW]) >= fixed_const(2000)) begin
      e.rates[LN_ELBOW] = scaled(ax[AX_ELBOW], q);
    end
    e.rates[LN_ROLL] = scaled(ax[AX_ROLL], q);

    // Claw moves only on a fresh press; open wins over close
    step = (longint'(claw_hi) - longint'(claw_lo)) / 2;
    if (b[BTN_OPEN] && !press_held) begin
      press_held = 1'b1;
      tgt = claw_pos + step;
      if (tgt > claw_hi || tgt < 0 || tgt > CLAW_TOP) begin
        e.lim = 1'b1;
      end else if (tgt != claw_pos) begin
        claw_pos = int'(tgt);
        e.req = 1'b1;
      end
    end else if (b[BTN_CLOSE] && !press_held) begin
      press_held = 1'b1;
      tgt = claw_pos - step;
      if (tgt < claw_lo || tgt < 0 || tgt > CLAW_TOP) begin
        e.lim = 1'b1;
      end else if (tgt != claw_pos) begin
        claw_pos = int'(tgt);
        e.req = 1'b1;
      end
    end else if (!b[BTN_OPEN] && !b[BTN_CLOSE]) begin
      press_held = 1'b0;
    end
    e.pos  = CLAW_W'(claw_pos);
    e.port = PORT_W'(claw_port);
    rates_due.push_back(e);
  endfunction

  function void report(string what, longint want, longint got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("check: result %0d %s expected %0d got %0d", results_seen, what, want, got);
    end
  endfunction

  function void check_rates(logic [OUT_DATA_W-1:0] d);
    joint_result_t want;
    joint_result_t got;
    string         lane_name[NUM_LANES];
    lane_name = '{"base_rate", "shoulder_rate", "upper_arm_rate", "elbow_rate",
                  "wrist_tilt_rate", "wrist_roll_rate"};
    results_seen++;
    if (rates_due.size() == 0) begin
      report("unexpected item, no sample pending", 0, 0);
      return;
    end
    want = rates_due.pop_front();
    got  = joint_result_t'(d[OUT_BITS-1:0]);
    for (int i = 0; i < NUM_LANES; i++) begin
      if (got.rates[i] !== want.rates[i]) begin
        report(lane_name[i], longint'($signed(want.rates[i])), longint'($signed(got.rates[i])));
      end
    end
    if (got.req !== want.req) report("claw_request", want.req, got.req);
    if (got.pos !== want.pos) report("claw_position", want.pos, got.pos);
    if (got.port !== want.port) report("claw_port", want.port, got.port);
    if (got.lim !== want.lim) report("claw_at_limit", want.lim, got.lim);
    if (d[OUT_DATA_W-1:OUT_BITS] !== '0) report("pad bits", 0, d[OUT_DATA_W-1:OUT_BITS]);
  endfunction
endclass

module tb;
  localparam int     CLK_PERIOD     = 8;
  localparam int     TIMEOUT_CYCLES = 600000;
  localparam int     PHASE_ITEMS    = 133;
  localparam int     NUM_PHASES     = 10;
  localparam int     HOLD_AFTER     = 250;
  localparam int     HOLD_CYCLES    = 300;
  localparam longint AXIS_TOP       = (longint'(1) << (AXIS_W - 1)) - 1;
  localparam longint AXIS_BOT       = -(longint'(1) << (AXIS_W - 1));

  localparam int B_TPLUS  = 1 << BTN_TILT_PLUS;
  localparam int B_TMINUS = 1 << BTN_TILT_MINUS;
  localparam int B_OPEN   = 1 << BTN_OPEN;
  localparam int B_CLOSE  = 1 << BTN_CLOSE;
  localparam int B_FWD    = 1 << BTN_FWD;
  localparam int B_BWD    = 1 << BTN_BWD;

  // Indexes the block does not decode
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = CFG_ADDR_W'(6);
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = CFG_ADDR_W'(7);

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int tx_idle_pct;
  int rx_idle_pct;

  joint_rate_scoreboard sb = new();

  joystick_to_arm_joint_rates dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(longint'(TIMEOUT_CYCLES) * CLK_PERIOD);
    $display("tb: done, errors");
    $finish;
  end

  function automatic logic [IN_DATA_W-1:0] pack_sample(input longint base, input longint roll,
                                                       input longint sh, input longint ua,
                                                       input longint el, input longint thr,
                                                       input int btn);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[AX_BASE*AXIS_W +: AXIS_W]     = AXIS_W'(base);
    d[AX_ROLL*AXIS_W +: AXIS_W]     = AXIS_W'(roll);
    d[AX_SHOULDER*AXIS_W +: AXIS_W] = AXIS_W'(sh);
    d[AX_UPPER*AXIS_W +: AXIS_W]    = AXIS_W'(ua);
    d[AX_ELBOW*AXIS_W +: AXIS_W]    = AXIS_W'(el);
    d[AX_THROTTLE*AXIS_W +: AXIS_W] = AXIS_W'(thr);
    d[BTN_LSB +: BTN_W]             = BTN_W'(btn);
    return d;
  endfunction

  function automatic longint stick();
    longint m;
    m = ($urandom_range(1) ? DZ_SH_MAG : DZ_EL_MAG) + longint'($urandom_range(2)) - 1;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(4))
          0: return AXIS_BOT;
          1: return AXIS_TOP;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      // hug the deadzone thresholds from both sides
      1: return $urandom_range(1) ? m : -m;
      default: return longint'($urandom_range(65535)) + AXIS_BOT;
    endcase
  endfunction

  function automatic longint throttle_pick();
    case ($urandom_range(5))
      0: return sb.thr_lo + longint'($urandom_range(2)) - 1;
      1: return sb.thr_hi + longint'($urandom_range(2)) - 1;
      default: return longint'($urandom_range(65535)) + AXIS_BOT;
    endcase
  endfunction

  function automatic logic [IN_DATA_W-1:0] random_sample();
    logic [BTN_W-1:0] b;
    b = BTN_W'($urandom_range(63));
    // keep presets off half the time so the sticks and tilt buttons get through
    if ($urandom_range(1)) begin
      b[BTN_FWD] = 1'b0;
      b[BTN_BWD] = 1'b0;
    end
    return pack_sample(stick(), stick(), stick(), stick(), stick(), throttle_pick(), int'(b));
  endfunction

  task automatic send_sample(input logic [IN_DATA_W-1:0] d);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    sb.take_sample(d);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.rates_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic program_regs(input int en, input int lo, input int hi, input int cmin,
                              input int cmax, input int port, input bit spare);
    put_reg(CFG_THROTTLE_ENABLE, CFG_DATA_W'(en));
    put_reg(CFG_THROTTLE_MIN, CFG_DATA_W'(lo));
    put_reg(CFG_THROTTLE_MAX, CFG_DATA_W'(hi));
    put_reg(CFG_CLAW_MIN, CFG_DATA_W'(cmin));
    put_reg(CFG_CLAW_MAX, CFG_DATA_W'(cmax));
    put_reg(CFG_CLAW_PORT, CFG_DATA_W'(port));
    if (spare) begin
      put_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
      put_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
    end
    cfg_we <= 1'b0;
  endtask

  task automatic apply_phase(input int ph);
    int a;
    int b;
    int tmp;
    a = int'($urandom_range(65535)) - 32768;
    b = int'($urandom_range(65535)) - 32768;
    if ($urandom_range(3) != 0 && a > b) begin
      tmp = a;
      a   = b;
      b   = tmp;
    end
    case (ph)
      1: program_regs(0, -32768, 32767, 0, 180, 0, 1'b0);
      // reversed claw limits give a negative step
      2: program_regs(1, 0, 16384, 180, 0, 255, 1'b0);
      3: program_regs(1, 100, 100, 50, 50, int'($urandom_range(255)), 1'b1);
      4: program_regs(1, 32767, -32768, 90, 91, int'($urandom_range(255)), 1'b0);
      5: program_regs(1, -32768, -32767, 10, 180, int'($urandom_range(255)), 1'b0);
      6: program_regs(1, 32766, 32767, 180, 180, int'($urandom_range(255)), 1'b0);
      default: program_regs(($urandom_range(4) != 0), a, b, int'($urandom_range(180)),
                            int'($urandom_range(180)), int'($urandom_range(255)), 1'b0);
    endcase
  endtask

  // Result side: check each item, stall at random, and hold off once for a long stretch
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_rates(out_tdata);
      if (hold_left == 0 && !hold_done && sb.results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    tx_idle_pct = 17;
    rx_idle_pct = 51;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples at the reset settings; claw starts at 63 with a step of 27
    send_sample(pack_sample(0, 0, 0, 0, 0, AXIS_TOP, 0));
    send_sample(pack_sample(AXIS_BOT, AXIS_TOP, AXIS_BOT, AXIS_BOT, AXIS_TOP, AXIS_TOP, 0));
    send_sample(pack_sample(AXIS_TOP, AXIS_BOT, DZ_SH_MAG, AXIS_TOP, DZ_EL_MAG, AXIS_TOP,
                            B_TPLUS));
    send_sample(pack_sample(1, -1, DZ_SH_MAG - 1, -1, DZ_EL_MAG - 1, AXIS_TOP, B_TMINUS));
    send_sample(pack_sample(-1, 1, -DZ_SH_MAG, 1, -DZ_EL_MAG, 0, B_TPLUS | B_TMINUS));
    send_sample(pack_sample(1000, -1000, 1 - DZ_SH_MAG, 5, 1 - DZ_EL_MAG, AXIS_TOP, B_FWD));
    send_sample(pack_sample(0, 0, 0, 0, 0, AXIS_TOP, B_BWD));
    send_sample(pack_sample(0, 0, AXIS_TOP, 0, 0, AXIS_TOP, B_FWD | B_BWD));
    send_sample(pack_sample(AXIS_TOP, AXIS_TOP, AXIS_TOP, AXIS_TOP, AXIS_TOP, AXIS_BOT, B_FWD));
    send_sample(pack_sample(12345, -12345, 777, -777, 9999, 0, B_BWD));
    send_sample(pack_sample(3, 3, 3, 3, 3, -1, B_OPEN));
    send_sample(pack_sample(0, 0, 0, 0, 0, AXIS_TOP, B_OPEN));
    send_sample(pack_sample(0, 0, 0, 0, 0, AXIS_TOP, 0));
    send_sample(pack_sample(0, 0, 0, 0, 0, AXIS_TOP, B_CLOSE));
    send_sample(pack_sample(0, 0, 0, 0, 0, AXIS_TOP, B_CLOSE));
    send_sample(pack_sample(0, 0, 0, 0, 0, AXIS_TOP, 0));
    send_sample(pack_sample(0, 0, 0, 0, 0, AXIS_TOP, B_CLOSE | B_TPLUS));
    send_sample(pack_sample(0, 0, 0, 0, 0, AXIS_TOP, 0));
    send_sample(pack_sample(0, 0, 0, 0, 0, AXIS_TOP, B_CLOSE));
    send_sample(pack_sample(0, 0, 0, 0, 0, AXIS_TOP, 0));
    send_sample(pack_sample(-20000, 20000, -5000, 30000, -7000, 16384, B_OPEN | B_CLOSE));
    send_sample(pack_sample(AXIS_BOT, AXIS_BOT, AXIS_BOT, AXIS_BOT, AXIS_BOT, AXIS_TOP, 63));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 4) begin
        tx_idle_pct = 51;
        rx_idle_pct = 17;
      end else if (ph == 7) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (ph > 0) begin
        drain_results();
        apply_phase(ph);
      end
      repeat (PHASE_ITEMS) send_sample(random_sample());
    end

    drain_results();
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.rates_due.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
